### rtl/point_transform_4x4_core_macros.svh
// Assertion macros used by the point transform checker.
`ifndef POINT_TRANSFORM_4X4_CORE_MACROS_SVH
`define POINT_TRANSFORM_4X4_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define PT4_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pt4 assertion failed");

// Plain invariant checked at every rising clock edge outside reset.
`define PT4_CHECK(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("pt4 invariant failed");

`endif

### rtl/pt4_pkg.sv
// Shared constants and types of the 4x4 point transform.
`default_nettype none
package pt4_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_COEF_REGS = 8;
  localparam int COEF_IDX_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int COORD_W = 32;
  localparam int REG_W = 64;
  localparam int ACC_W = 68;
  localparam int ROW_W = 59;
  localparam int QDEPTH = 4;
  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 3;

  typedef struct packed {
    logic                            mode;
    logic [NUM_ROWS-1:0][ROW_W-1:0]  row;
  } pt4_entry_t;
endpackage
`default_nettype wire

### rtl/point_transform_4x4_core.sv
// Affine mode: one point per cycle sustained while no divide is in progress.
// Projective mode: a point with w == 0 skips the divide; otherwise the three
// 64-step bit-serial divider lanes take one point at a time.
// A 4-entry queue decouples the front pipeline from the divide; busy_o is high
// while all queue credits are taken. Reset loads the identity matrix and empties
// all pipeline stages and the queue.
`default_nettype none
module point_transform_4x4_core import pt4_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  mode_i,
  input  wire logic [COORD_W-1:0]    point_x_i,
  input  wire logic [COORD_W-1:0]    point_y_i,
  input  wire logic [COORD_W-1:0]    point_z_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [REG_W-1:0]      cfg_wdata_i,
  output logic                       out_valid_o,
  output logic [COORD_W-1:0]         out_x_o,
  output logic [COORD_W-1:0]         out_y_o,
  output logic [COORD_W-1:0]         out_z_o,
  output logic                       w_zero_o,
  output logic                       saturated_o
);
  localparam logic [REG_W-1:0] One = REG_W'(1) << FracBits;
  localparam int CredW = $clog2(QDEPTH + 1);
  // identity matrix, register 7 first
  localparam logic [NUM_COEF_REGS-1:0][REG_W-1:0] CoefReset =
    {One << COORD_W, REG_W'(0), One, REG_W'(0),
     REG_W'(0), One << COORD_W, REG_W'(0), One};

  logic [NUM_COEF_REGS-1:0][REG_W-1:0] coef_q;
  logic [CredW-1:0]  cred_q, cred_d;
  logic              accept;
  logic              f_valid;
  pt4_entry_t        f_entry;
  pt4_entry_t        q_entry;
  logic              q_empty;
  logic              pop;

  assign busy_o = (cred_q == CredW'(QDEPTH));
  assign accept = start_i && !busy_o;

  always_comb begin
    cred_d = cred_q;
    if (accept && !pop) begin
      cred_d = cred_q + 1'b1;
    end else if (pop && !accept) begin
      cred_d = cred_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
      coef_q <= CoefReset;
    end else begin
      cred_q <= cred_d;
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_COEF_REGS))) begin
        coef_q[cfg_idx_i[COEF_IDX_W-1:0]] <= cfg_wdata_i;
      end
    end
  end

  pt4_front #(.FracBits(FracBits)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .mode_i    (mode_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .point_z_i (point_z_i),
    .coef_i    (coef_q),
    .valid_o   (f_valid),
    .entry_o   (f_entry)
  );

  pt4_fifo #(.Depth(QDEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_entry),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (q_entry)
  );

  pt4_back #(.FracBits(FracBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .entry_i     (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .w_zero_o    (w_zero_o),
    .saturated_o (saturated_o)
  );
endmodule
`default_nettype wire

### rtl/pt4_front.sv
// Front pipeline: products, partial sums and rounding of the four row values.
`default_nettype none
module pt4_front import pt4_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  input  wire logic                                 mode_i,
  input  wire logic signed [COORD_W-1:0]            point_x_i,
  input  wire logic signed [COORD_W-1:0]            point_y_i,
  input  wire logic signed [COORD_W-1:0]            point_z_i,
  input  wire logic [NUM_COEF_REGS-1:0][REG_W-1:0]  coef_i,
  output logic                                      valid_o,
  output pt4_entry_t                                entry_o
);
  localparam logic signed [ACC_W-1:0] Half = ACC_W'(1) << (FracBits - 1);

  logic                              a_valid_q, a_valid_d;
  logic                              a_mode_q, a_mode_d;
  logic signed [REG_W-1:0]           a_prod_q [NUM_ROWS][NUM_COLS];
  logic signed [REG_W-1:0]           a_prod_d [NUM_ROWS][NUM_COLS];
  logic                              b_valid_q, b_valid_d;
  logic                              b_mode_q, b_mode_d;
  logic signed [ACC_W-1:0]           b_s01_q [NUM_ROWS];
  logic signed [ACC_W-1:0]           b_s01_d [NUM_ROWS];
  logic signed [ACC_W-1:0]           b_s2c_q [NUM_ROWS];
  logic signed [ACC_W-1:0]           b_s2c_d [NUM_ROWS];
  logic signed [COORD_W-1:0]         pt [NUM_COLS];

  function automatic logic signed [COORD_W-1:0] coef_get(
    input logic [NUM_COEF_REGS-1:0][REG_W-1:0] regs, input int r, input int c);
    logic [REG_W-1:0] word;
    word = regs[r*2 + (c >> 1)];
    return (c % 2 == 1) ? $signed(word[REG_W-1:COORD_W]) : $signed(word[COORD_W-1:0]);
  endfunction

  always_comb begin
    pt[0] = point_x_i;
    pt[1] = point_y_i;
    pt[2] = point_z_i;
    a_valid_d = valid_i;
    a_mode_d = mode_i;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        a_prod_d[r][c] = coef_get(coef_i, r, c) * pt[c];
      end
    end
    b_valid_d = a_valid_q;
    b_mode_d = a_mode_q;
    for (int r = 0; r < NUM_ROWS; r++) begin
      b_s01_d[r] = ACC_W'(a_prod_q[r][0]) + ACC_W'(a_prod_q[r][1]);
      b_s2c_d[r] = ACC_W'(a_prod_q[r][2]) + (ACC_W'(coef_get(coef_i, r, 3)) <<< FracBits)
                   + Half;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mode_q <= a_mode_d;
    a_prod_q <= a_prod_d;
    b_mode_q <= b_mode_d;
    b_s01_q <= b_s01_d;
    b_s2c_q <= b_s2c_d;
  end

  always_comb begin
    logic signed [ACC_W-1:0] tot;
    logic signed [ACC_W-1:0] shifted;
    valid_o = b_valid_q;
    entry_o.mode = b_mode_q;
    for (int r = 0; r < NUM_ROWS; r++) begin
      tot = b_s01_q[r] + b_s2c_q[r];
      shifted = tot >>> FracBits;
      entry_o.row[r] = shifted[ROW_W-1:0];
    end
  end
endmodule
`default_nettype wire

### rtl/pt4_fifo.sv
// Small queue of row-value items between the front and back parts.
`default_nettype none
module pt4_fifo import pt4_pkg::*; #(
  parameter int Depth = QDEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire pt4_entry_t  data_i,
  input  wire logic        pop_i,
  output logic             empty_o,
  output pt4_entry_t       data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pt4_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign empty_o = (cnt_q == '0);
  assign data_o = mem_q[rd_q];
endmodule
`default_nettype wire

### rtl/pt4_back.sv
// Back part: saturation, zero-w handling and bit-serial perspective divide.
`default_nettype none
module pt4_back import pt4_pkg::*; #(
  parameter int FracBits = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  input  wire pt4_entry_t            entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  output logic [COORD_W-1:0]         out_x_o,
  output logic [COORD_W-1:0]         out_y_o,
  output logic [COORD_W-1:0]         out_z_o,
  output logic                       w_zero_o,
  output logic                       saturated_o
);
  localparam int DivSteps = REG_W;
  localparam int StepW = $clog2(DivSteps);
  localparam logic [COORD_W-1:0] SMax = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SMin = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic {ST_IDLE, ST_DIV} state_e;

  state_e               state_q, state_d;
  logic [StepW-1:0]     cnt_q, cnt_d;
  logic [REG_W-1:0]     rem_q [NUM_COLS];
  logic [REG_W-1:0]     rem_d [NUM_COLS];
  logic [REG_W-1:0]     quo_q [NUM_COLS];
  logic [REG_W-1:0]     quo_d [NUM_COLS];
  logic                 neg_q [NUM_COLS];
  logic                 neg_d [NUM_COLS];
  logic [REG_W-1:0]     div_q, div_d;
  logic                 valid_q, valid_d;
  logic [COORD_W-1:0]   res_q [NUM_COLS];
  logic [COORD_W-1:0]   res_d [NUM_COLS];
  logic                 wz_q, wz_d;
  logic                 sat_q, sat_d;

  function automatic logic [REG_W-1:0] mag(input logic [ROW_W-1:0] v);
    logic [REG_W-1:0] ext;
    ext = REG_W'($signed(v));
    return v[ROW_W-1] ? (~ext + 1'b1) : ext;
  endfunction

  always_comb begin
    logic [REG_W:0]     sh;
    logic               ge;
    logic [ROW_W-1:0]   v;
    logic [ROW_W-COORD_W:0] hi;
    logic [REG_W-1:0]   q;
    logic [REG_W-1:0]   nq;
    state_d = state_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    div_d = div_q;
    valid_d = 1'b0;
    res_d = res_q;
    wz_d = wz_q;
    sat_d = sat_q;
    pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (!entry_i.mode) begin
            valid_d = 1'b1;
            wz_d = 1'b0;
            sat_d = 1'b0;
            for (int i = 0; i < NUM_COLS; i++) begin
              v = entry_i.row[i];
              hi = v[ROW_W-1:COORD_W-1];
              if (&hi || ~|hi) begin
                res_d[i] = v[COORD_W-1:0];
              end else begin
                res_d[i] = v[ROW_W-1] ? SMin : SMax;
                sat_d = 1'b1;
              end
            end
          end else if (entry_i.row[3] == '0) begin
            valid_d = 1'b1;
            wz_d = 1'b1;
            sat_d = 1'b0;
            for (int i = 0; i < NUM_COLS; i++) begin
              res_d[i] = '0;
            end
          end else begin
            state_d = ST_DIV;
            cnt_d = '0;
            div_d = mag(entry_i.row[3]);
            for (int i = 0; i < NUM_COLS; i++) begin
              rem_d[i] = '0;
              quo_d[i] = mag(entry_i.row[i]) << FracBits;
              neg_d[i] = entry_i.row[i][ROW_W-1] ^ entry_i.row[3][ROW_W-1];
            end
          end
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        for (int i = 0; i < NUM_COLS; i++) begin
          sh = {rem_q[i], quo_q[i][REG_W-1]};
          ge = (sh >= {1'b0, div_q});
          rem_d[i] = ge ? REG_W'(sh - {1'b0, div_q}) : sh[REG_W-1:0];
          quo_d[i] = {quo_q[i][REG_W-2:0], ge};
        end
        if (cnt_q == StepW'(DivSteps - 1)) begin
          state_d = ST_IDLE;
          valid_d = 1'b1;
          wz_d = 1'b0;
          sat_d = 1'b0;
          for (int i = 0; i < NUM_COLS; i++) begin
            q = quo_d[i];
            nq = ~q + 1'b1;
            if (neg_q[i]) begin
              if (q > REG_W'(SMin)) begin
                res_d[i] = SMin;
                sat_d = 1'b1;
              end else begin
                res_d[i] = nq[COORD_W-1:0];
              end
            end else if (q > REG_W'(SMax)) begin
              res_d[i] = SMax;
              sat_d = 1'b1;
            end else begin
              res_d[i] = q[COORD_W-1:0];
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      valid_q <= 1'b0;
      wz_q <= 1'b0;
      sat_q <= 1'b0;
      div_q <= '0;
      for (int i = 0; i < NUM_COLS; i++) begin
        rem_q[i] <= '0;
        quo_q[i] <= '0;
        neg_q[i] <= 1'b0;
        res_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      valid_q <= valid_d;
      wz_q <= wz_d;
      sat_q <= sat_d;
      div_q <= div_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      neg_q <= neg_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_x_o = res_q[0];
  assign out_y_o = res_q[1];
  assign out_z_o = res_q[2];
  assign w_zero_o = wz_q;
  assign saturated_o = sat_q;
endmodule
`default_nettype wire

### rtl/pt4_checker.sv
// Port-level checks of the point transform core and their bind.
`default_nettype none
`include "point_transform_4x4_core_macros.svh"
module pt4_checker import pt4_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start_i,
  input wire logic                  busy_o,
  input wire logic                  out_valid_o,
  input wire logic [COORD_W-1:0]    out_x_o,
  input wire logic [COORD_W-1:0]    out_y_o,
  input wire logic [COORD_W-1:0]    out_z_o,
  input wire logic                  w_zero_o,
  input wire logic                  saturated_o
);
  localparam logic [COORD_W-1:0] SMax = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SMin = {1'b1, {(COORD_W-1){1'b0}}};

  `PT4_ASSERT(a_wz_zero, out_valid_o && w_zero_o, out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
  `PT4_ASSERT(a_sat_ext, out_valid_o && saturated_o, out_x_o == SMax || out_x_o == SMin || out_y_o == SMax || out_y_o == SMin || out_z_o == SMax || out_z_o == SMin)
  `PT4_ASSERT(a_busy_rise, $rose(busy_o), $past(start_i))
  `PT4_CHECK(a_flag_excl, !(w_zero_o && saturated_o))
endmodule

bind point_transform_4x4_core pt4_checker u_pt4_checker (.*);
`default_nettype wire

### sim/tb_point_transform_4x4_core.sv
// Self-checking testbench for the 4x4 point transform core: directed table, then random phases.
`default_nettype none
module tb_point_transform_4x4_core;
  import pt4_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } point_res_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        known;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic                 mode_i = 1'b0;
  logic [COORD_W-1:0]   point_x_i = '0;
  logic [COORD_W-1:0]   point_y_i = '0;
  logic [COORD_W-1:0]   point_z_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [REG_W-1:0]     cfg_wdata_i = '0;
  logic                 out_valid_o;
  logic [COORD_W-1:0]   out_x_o, out_y_o, out_z_o;
  logic                 w_zero_o, saturated_o;

  logic [REG_W-1:0] coef_copy [NUM_COEF_REGS];
  point_res_t       expected_pts[$];
  int               err_cnt = 0;
  int               idle_cycles = 0;

  point_transform_4x4_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint coef_at(int r, int c);
    logic [63:0] rv;
    rv = coef_copy[r*2 + c/2];
    return longint'(signed'((c % 2) ? rv[63:32] : rv[31:0]));
  endfunction

  function automatic logic signed [127:0] row_dot(int r, longint px, longint py, longint pz);
    logic signed [127:0] acc;
    acc = 128'sd0;
    acc = acc + (coef_at(r, 0) * px);
    acc = acc + (coef_at(r, 1) * py);
    acc = acc + (coef_at(r, 2) * pz);
    acc = acc + (coef_at(r, 3) * 64'sd65536);
    acc = acc + 128'sd32768;
    return acc >>> FB;
  endfunction

  function automatic point_res_t transform_point(logic mode, logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
    point_res_t res;
    logic signed [127:0] rv [3];
    logic signed [127:0] w;
    logic [31:0] o [3];
    logic [63:0] na, nw, q;
    logic neg;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      rv[i] = row_dot(i, longint'(signed'(x)), longint'(signed'(y)), longint'(signed'(z)));
    end
    if (mode) begin
      w = row_dot(3, longint'(signed'(x)), longint'(signed'(y)), longint'(signed'(z)));
      if (w == 0) begin
        res.wz = 1'b1;
        o = '{default: 32'd0};
      end else begin
        for (int i = 0; i < 3; i++) begin
          neg = (rv[i] < 0) != (w < 0);
          na = (rv[i] < 0) ? 64'(-rv[i]) : 64'(rv[i]);
          nw = (w < 0) ? 64'(-w) : 64'(w);
          q = (na << FB) / nw;
          if (neg) begin
            if (q > 64'h8000_0000) begin
              res.sat = 1'b1;
              o[i] = S_MIN;
            end else begin
              o[i] = 32'(-q);
            end
          end else if (q > 64'h7FFF_FFFF) begin
            res.sat = 1'b1;
            o[i] = S_MAX;
          end else begin
            o[i] = q[31:0];
          end
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (rv[i] > 128'sd2147483647) begin
          res.sat = 1'b1;
          o[i] = S_MAX;
        end else if (rv[i] < -128'sd2147483648) begin
          res.sat = 1'b1;
          o[i] = S_MIN;
        end else begin
          o[i] = rv[i][31:0];
        end
      end
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    point_res_t want;
    if (rst_ni && out_valid_o) begin
      if (expected_pts.size() == 0) begin
        report_mismatch("unexpected item", out_x_o, 32'd0);
      end else begin
        want = expected_pts.pop_front();
        if (out_x_o !== want.x) report_mismatch("out_x", out_x_o, want.x);
        if (out_y_o !== want.y) report_mismatch("out_y", out_y_o, want.y);
        if (out_z_o !== want.z) report_mismatch("out_z", out_z_o, want.z);
        if (w_zero_o !== want.wz) report_mismatch("w_zero", w_zero_o, want.wz);
        if (saturated_o !== want.sat) report_mismatch("saturated", saturated_o, want.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || out_valid_o || (start_i && !busy_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_point(int gap, logic mode, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic known);
    point_res_t pred;
    logic taken;
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    mode_i = mode;
    point_x_i = x;
    point_y_i = y;
    point_z_i = z;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
    pred = transform_point(mode, x, y, z);
    if (known && pred != {x, y, z, 2'b00}) begin
      report_mismatch("identity table", pred.x, x);
    end
    expected_pts.push_back(known ? point_res_t'({x, y, z, 2'b00}) : pred);
    @(negedge clk_i);
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    if (idx < NUM_COEF_REGS) coef_copy[idx] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    start_i = 1'b0;
    while (expected_pts.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      1: return ($urandom_range(0, 1)) ? S_MAX : S_MIN;
      2: return 32'($urandom_range(0, 3)) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(int style);
    case (style)
      0: return rand_word(0);
      1: return rand_word(1);
      2: return ($urandom_range(0, 1)) ? Q_ONE : 32'd0;
      default: return rand_word($urandom_range(0, 3));
    endcase
  endfunction

  stim_row_t dir_rows [] = '{
    '{1'b0, Q_ONE, 32'h0002_0000, 32'h0003_0000, 1'b1},
    '{1'b0, S_MAX, S_MIN, 32'd0, 1'b1},
    '{1'b0, S_MIN, S_MAX, 32'hFFFF_FFFF, 1'b1},
    '{1'b0, 32'd1, 32'hFFFF_FFFF, 32'h0000_8000, 1'b1},
    '{1'b1, Q_ONE, 32'hFFFE_0000, 32'h0000_0001, 1'b1},
    '{1'b1, S_MAX, S_MIN, S_MAX, 1'b1},
    '{1'b1, S_MIN, 32'd0, S_MIN, 1'b1},
    '{1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b1},
    '{1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0, 1'b1},
    '{1'b1, 32'd0, 32'd0, 32'd0, 1'b1}
  };

  initial begin
    int mode_style, pt_kind, coef_style, gap;
    logic burst;
    coef_copy[0] = 64'(Q_ONE);
    coef_copy[1] = 64'd0;
    coef_copy[2] = {Q_ONE, 32'd0};
    coef_copy[3] = 64'd0;
    coef_copy[4] = 64'd0;
    coef_copy[5] = 64'(Q_ONE);
    coef_copy[6] = 64'd0;
    coef_copy[7] = {Q_ONE, 32'd0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_point(i % 3, dir_rows[i].mode, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                 dir_rows[i].known);
    end

    for (int ph = 0; ph < 11; ph++) begin
      wait_drained();
      // 0: w row zeroed, 1: all max, 2: all min, rest random
      for (int r = 0; r < NUM_COEF_REGS; r++) begin
        coef_style = $urandom_range(0, 3);
        case (ph)
          0: write_coef(r, (r >= 6) ? 64'd0 : {rand_coef(coef_style), rand_coef(coef_style)});
          1: write_coef(r, {S_MAX, S_MAX});
          2: write_coef(r, {S_MIN, S_MIN});
          default: write_coef(r, {rand_coef(coef_style), rand_coef(coef_style)});
        endcase
      end
      write_coef(4'($urandom_range(NUM_COEF_REGS, 15)), {$urandom(), $urandom()});
      if (ph == 3) begin
        // zero-rounding row 3 with nonzero inputs: w from rounding only
        write_coef(6, {32'd1, 32'd1});
        write_coef(7, 64'd0);
      end
      burst = (ph % 3 == 1);
      mode_style = $urandom_range(0, 2);
      for (int n = 0; n < 100; n++) begin
        pt_kind = $urandom_range(0, 3);
        gap = burst ? ($urandom_range(0, 7) == 0 ? 17 : 0) : $urandom_range(0, 17);
        send_point(gap, (mode_style == 2) ? 1'($urandom()) : 1'(mode_style),
                   rand_word(pt_kind), rand_word($urandom_range(0, 3)),
                   rand_word(pt_kind), 1'b0);
      end
    end

    start_i = 1'b0;
    while (expected_pts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/pt4_pkg.sv
rtl/pt4_front.sv
rtl/pt4_fifo.sv
rtl/pt4_back.sv
rtl/point_transform_4x4_core.sv
rtl/pt4_checker.sv
sim/tb_point_transform_4x4_core.sv
